[rtl/core/small_vector_alu_defines.svh]
// ----------------------------------------------------------------------------
// small_vector_alu assertion macros
// shared concurrent assertion wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef SMALL_VECTOR_ALU_DEFINES_SVH
`define SMALL_VECTOR_ALU_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SVA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("small_vector_alu assertion failed");
`define SVA_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("small_vector_alu forbidden condition");
`else
`define SVA_ASSERT(lbl, prop)
`define SVA_NEVER(lbl, expr)
`endif

`endif

[rtl/core/svalu_pkg.sv]
// ----------------------------------------------------------------------------
// svalu_pkg
// types, operation codes and helpers shared by the vector alu modules
// ----------------------------------------------------------------------------
package svalu_pkg;

  localparam int unsigned LANES      = 4;
  localparam int unsigned SQ_STAGES  = 32;
  localparam int unsigned DIV_STAGES = 17;
  localparam int unsigned PIPE       = 3 + SQ_STAGES + DIV_STAGES;

  localparam logic [2:0] KIND_ADD   = 3'd0;
  localparam logic [2:0] KIND_SUB   = 3'd1;
  localparam logic [2:0] KIND_SCALE = 3'd2;
  localparam logic [2:0] KIND_DOT   = 3'd3;
  localparam logic [2:0] KIND_CROSS = 3'd4;
  localparam logic [2:0] KIND_NEG   = 3'd5;
  localparam logic [2:0] KIND_LEN   = 3'd6;
  localparam logic [2:0] KIND_NORM  = 3'd7;

  localparam logic [2:0] DIM_RESET = 3'd3;
  localparam logic [2:0] DIM_MIN   = 3'd2;
  localparam logic [2:0] DIM_MAX   = 3'd4;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [31:0] a3;
    logic signed [31:0] b0;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic signed [31:0] b3;
    logic signed [31:0] factor;
  } in_t;

  typedef struct packed {
    logic signed [31:0] r0;
    logic signed [31:0] r1;
    logic signed [31:0] r2;
    logic signed [31:0] r3;
    logic signed [31:0] scalar_result;
    logic               saturated;
    logic               zero_length;
  } out_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  // item context carried alongside the root and divide pipes
  typedef struct packed {
    logic [2:0]        kind;
    logic [3:0][31:0]  r;
    logic [31:0]       sc;
    logic              sat;
    logic              carry;
    logic [32:0]       len;
  } side_t;

  function automatic sat_t sat32_f(input logic signed [65:0] v);
    sat_t s;
    if (v > 66'sd2147483647) begin
      s.clip = 1'b1;
      s.val  = 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      s.clip = 1'b1;
      s.val  = 32'sh8000_0000;
    end else begin
      s.clip = 1'b0;
      s.val  = v[31:0];
    end
    return s;
  endfunction

  // (base) mod n for base below 6 and n in 2..4
  function automatic logic [1:0] cyc_idx_f(input logic [2:0] base, input logic [2:0] n);
    logic [2:0] s;
    s = base;
    if (s >= n) s = s - n;
    if (s >= n) s = s - n;
    return s[1:0];
  endfunction

endpackage

[rtl/core/small_vector_alu.sv]
// ----------------------------------------------------------------------------
// small_vector_alu
// Q16.16 vector operations on up to four components, fully pipelined
// ----------------------------------------------------------------------------
// One beat in, one beat out, a new beat every cycle while the output is not
// stalled. Each beat passes through operand select, lane multiply and lane
// result, the bit-per-stage square root, the per-lane divider, then the
// output register. Every operation travels the full depth so results leave
// in order. The whole pipe advances whenever the output register is empty or
// being taken, so a stalled output holds everything back and in_stall_o
// follows out_stall_i while the output register holds a beat.
// The dimension register may only be written while nothing is in flight.
module small_vector_alu (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  svalu_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output svalu_pkg::out_t  out_data_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_data_i
);
  import svalu_pkg::*;

  `include "small_vector_alu_defines.svh"

  logic             adv;
  logic [2:0]       dim_q, n_dim;
  logic [PIPE-1:0]  v_q;
  logic             out_valid_q;
  out_t             out_q, out_d;

  // operand stage
  logic signed [31:0] a_in [LANES];
  logic signed [31:0] b_in [LANES];
  logic signed [31:0] x1_d [LANES], y1_d [LANES], x2_d [LANES], y2_d [LANES];
  logic signed [31:0] a_aq [LANES], b_aq [LANES];
  logic signed [31:0] x1_q [LANES], y1_q [LANES], x2_q [LANES], y2_q [LANES];
  logic [LANES-1:0]   en_d, en_q;
  logic signed [31:0] f_q;
  logic [2:0]         kind_a_q, kind_b_q, kind_c_q;

  // lane outputs
  logic signed [31:0] lane_r   [LANES];
  logic [LANES-1:0]   lane_sat;
  logic signed [63:0] lane_pab [LANES];
  logic [63:0]        lane_paa [LANES];

  // merge stage
  logic signed [65:0] dot_sum;
  logic [65:0]        sq_sum;
  sat_t               dot_s;
  logic signed [31:0] sc_c_q;
  logic               dsat_c_q, carry_c_q;
  logic [63:0]        s_c_q;
  side_t              side_in, side_mid;
  side_t              side_q  [SQ_STAGES];
  side_t              side2_q [DIV_STAGES];
  logic [31:0]        root;
  logic [16:0]        quo [LANES];
  side_t              fin;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // dimension register, out-of-range codes clamp to 2 or 4
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      dim_q <= cfg_data_i;
    end
  end

  assign n_dim = (dim_q < DIM_MIN) ? DIM_MIN : ((dim_q > DIM_MAX) ? DIM_MAX : dim_q);

  // valid bits travel beside the payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q         <= {v_q[PIPE-2:0], in_valid_i};
      out_valid_q <= v_q[PIPE-1];
    end
  end

  // cyclic cross operands: lane i takes a[i+1]*b[i+2] - a[i+2]*b[i+1] mod n
  always_comb begin
    a_in = '{in_data_i.a0, in_data_i.a1, in_data_i.a2, in_data_i.a3};
    b_in = '{in_data_i.b0, in_data_i.b1, in_data_i.b2, in_data_i.b3};
    for (int i = 0; i < LANES; i++) begin
      x1_d[i] = a_in[cyc_idx_f(3'(i + 1), n_dim)];
      y1_d[i] = b_in[cyc_idx_f(3'(i + 2), n_dim)];
      x2_d[i] = a_in[cyc_idx_f(3'(i + 2), n_dim)];
      y2_d[i] = b_in[cyc_idx_f(3'(i + 1), n_dim)];
      en_d[i] = (3'(i) < n_dim);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        a_aq[i] <= a_in[i];
        b_aq[i] <= b_in[i];
        x1_q[i] <= x1_d[i];
        y1_q[i] <= y1_d[i];
        x2_q[i] <= x2_d[i];
        y2_q[i] <= y2_d[i];
      end
      en_q     <= en_d;
      f_q      <= in_data_i.factor;
      kind_a_q <= in_data_i.kind;
      kind_b_q <= kind_a_q;
      kind_c_q <= kind_b_q;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    svalu_lane u_lane (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .kind_i (kind_a_q),
      .en_i   (en_q[l]),
      .a_i    (a_aq[l]),
      .b_i    (b_aq[l]),
      .f_i    (f_q),
      .x1_i   (x1_q[l]),
      .y1_i   (y1_q[l]),
      .x2_i   (x2_q[l]),
      .y2_i   (y2_q[l]),
      .r_o    (lane_r[l]),
      .sat_o  (lane_sat[l]),
      .pab_o  (lane_pab[l]),
      .paa_o  (lane_paa[l])
    );
  end

  // merge: dot product and sum of squares across lanes
  always_comb begin
    dot_sum = '0;
    sq_sum  = '0;
    for (int i = 0; i < LANES; i++) begin
      dot_sum = dot_sum + 66'(lane_pab[i]);
      sq_sum  = sq_sum + {2'b00, lane_paa[i]};
    end
    dot_s = sat32_f(dot_sum >>> 16);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_c_q    <= (kind_b_q == KIND_DOT) ? dot_s.val : 32'sd0;
      dsat_c_q  <= (kind_b_q == KIND_DOT) && dot_s.clip;
      s_c_q     <= sq_sum[63:0];
      carry_c_q <= |sq_sum[65:64];
    end
  end

  always_comb begin
    side_in.kind  = kind_c_q;
    for (int i = 0; i < LANES; i++) begin
      side_in.r[i] = lane_r[i];
    end
    side_in.sc    = sc_c_q;
    side_in.sat   = dsat_c_q || (|lane_sat);
    side_in.carry = carry_c_q;
    side_in.len   = '0;
  end

  svalu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .rad_i  (s_c_q),
    .root_o (root)
  );

  // context rides along the root pipe
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int s = 1; s < SQ_STAGES; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // sum of squares past 64 bits means a length of exactly 2^32
  always_comb begin
    side_mid     = side_q[SQ_STAGES-1];
    side_mid.len = side_mid.carry ? {1'b1, 32'h0} : {1'b0, root};
  end

  for (genvar l = 0; l < LANES; l++) begin : g_div
    logic [31:0] mag;
    assign mag = side_mid.r[l][31] ? 32'(-side_mid.r[l]) : side_mid.r[l];

    svalu_div u_div (
      .clk_i (clk_i),
      .adv_i (adv),
      .mag_i (mag),
      .len_i (side_mid.len),
      .q_o   (quo[l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side2_q[0] <= side_mid;
      for (int s = 1; s < DIV_STAGES; s++) begin
        side2_q[s] <= side2_q[s-1];
      end
    end
  end

  // final select for length and normalize
  always_comb begin
    fin = side2_q[DIV_STAGES-1];
    out_d.zero_length = 1'b0;
    if (fin.kind == KIND_LEN) begin
      if (fin.len > 33'h0_7FFF_FFFF) begin
        fin.sat = 1'b1;
        fin.sc  = 32'h7FFF_FFFF;
      end else begin
        fin.sc = fin.len[31:0];
      end
    end else if (fin.kind == KIND_NORM) begin
      if (fin.len == '0) begin
        out_d.zero_length = 1'b1;
      end else begin
        for (int i = 0; i < LANES; i++) begin
          fin.r[i] = fin.r[i][31] ? 32'(-{15'h0, quo[i]}) : {15'h0, quo[i]};
        end
      end
    end
    out_d.r0            = fin.r[0];
    out_d.r1            = fin.r[1];
    out_d.r2            = fin.r[2];
    out_d.r3            = fin.r[3];
    out_d.scalar_result = fin.sc;
    out_d.saturated     = fin.sat;
  end

  // output register parts the pipe from the consumer
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SVA_ASSERT(a_zl_no_scalar, (out_valid_q && out_q.zero_length) |-> (out_q.scalar_result == 0))
  `SVA_NEVER(a_zl_no_sat, out_valid_q && out_q.zero_length && out_q.saturated)
  `SVA_ASSERT(a_hold_pipe, (out_valid_q && out_stall_i) |=> $stable(v_q))

endmodule

[rtl/core/svalu_lane.sv]
// ----------------------------------------------------------------------------
// svalu_lane
// one component lane: products, then saturated element result
// ----------------------------------------------------------------------------
module svalu_lane (
  input  logic               clk_i,
  input  logic               adv_i,
  input  logic [2:0]         kind_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] f_i,
  input  logic signed [31:0] x1_i,
  input  logic signed [31:0] y1_i,
  input  logic signed [31:0] x2_i,
  input  logic signed [31:0] y2_i,
  output logic signed [31:0] r_o,
  output logic               sat_o,
  output logic signed [63:0] pab_o,
  output logic [63:0]        paa_o
);
  import svalu_pkg::*;

  logic [2:0]         kind_q;
  logic               en_q;
  logic signed [31:0] a_q, b_q;
  logic signed [63:0] pab_q, paf_q, paa_q, pc1_q, pc2_q;
  logic signed [31:0] r_q, r_d;
  logic               sat_q, sat_d;
  logic signed [65:0] diff;
  sat_t               s;

  // product stage
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      kind_q <= kind_i;
      en_q   <= en_i;
      a_q    <= a_i;
      b_q    <= b_i;
      pab_q  <= 64'(a_i) * 64'(b_i);
      paf_q  <= 64'(a_i) * 64'(f_i);
      paa_q  <= 64'(a_i) * 64'(a_i);
      pc1_q  <= 64'(x1_i) * 64'(y1_i);
      pc2_q  <= 64'(x2_i) * 64'(y2_i);
    end
  end

  always_comb begin
    diff  = 66'(pc1_q) - 66'(pc2_q);
    s     = '0;
    r_d   = '0;
    sat_d = 1'b0;
    case (kind_q)
      KIND_ADD:   s = sat32_f(66'(a_q) + 66'(b_q));
      KIND_SUB:   s = sat32_f(66'(a_q) - 66'(b_q));
      KIND_SCALE: s = sat32_f(66'(paf_q >>> 16));
      KIND_CROSS: s = sat32_f(diff >>> 16);
      KIND_NEG:   s = sat32_f(-66'(a_q));
      KIND_NORM:  s = '{clip: 1'b0, val: a_q};
      default:    s = '0;
    endcase
    if (en_q) begin
      r_d   = s.val;
      sat_d = s.clip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r_q   <= r_d;
      sat_q <= sat_d;
    end
  end

  assign r_o   = r_q;
  assign sat_o = sat_q;
  assign pab_o = en_q ? pab_q : 64'sd0;
  assign paa_o = en_q ? 64'(paa_q) : 64'd0;

endmodule

[rtl/core/svalu_sqrt.sv]
// ----------------------------------------------------------------------------
// svalu_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module svalu_sqrt (
  input  logic        clk_i,
  input  logic        adv_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);
  import svalu_pkg::*;

  logic [32:0] rem_q  [SQ_STAGES];
  logic [31:0] root_q [SQ_STAGES];
  logic [63:0] rad_q  [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    logic [32:0] rem_p;
    logic [31:0] root_p;
    logic [63:0] rad_p;
    logic [34:0] remx, trial;
    logic        ge;

    if (g == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
    end else begin : g_next
      assign rem_p  = rem_q[g-1];
      assign root_p = root_q[g-1];
      assign rad_p  = rad_q[g-1];
    end

    assign remx  = {rem_p, rad_p[63:62]};
    assign trial = {1'b0, root_p, 2'b01};
    assign ge    = (remx >= trial);

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[g]  <= ge ? 33'(remx - trial) : remx[32:0];
        root_q[g] <= {root_p[30:0], ge};
        rad_q[g]  <= {rad_p[61:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[SQ_STAGES-1];

endmodule

[rtl/core/svalu_div.sv]
// ----------------------------------------------------------------------------
// svalu_div
// pipelined restoring divide of magnitude * 2^16 by the length
// ----------------------------------------------------------------------------
module svalu_div (
  input  logic        clk_i,
  input  logic        adv_i,
  input  logic [31:0] mag_i,
  input  logic [32:0] len_i,
  output logic [16:0] q_o
);
  import svalu_pkg::*;

  logic [32:0] rem_q [DIV_STAGES];
  logic [16:0] num_q [DIV_STAGES];
  logic [16:0] quo_q [DIV_STAGES];
  logic [32:0] len_q [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [32:0] rem_p, len_p;
    logic [16:0] num_p, quo_p;
    logic [33:0] remx;
    logic        ge;

    if (g == 0) begin : g_first
      // quotient fits 17 bits, so the top of the dividend starts below the divisor
      assign rem_p = {2'b00, mag_i[31:1]};
      assign num_p = {mag_i[0], 16'h0000};
      assign quo_p = '0;
      assign len_p = len_i;
    end else begin : g_next
      assign rem_p = rem_q[g-1];
      assign num_p = num_q[g-1];
      assign quo_p = quo_q[g-1];
      assign len_p = len_q[g-1];
    end

    assign remx = {rem_p, num_p[16]};
    assign ge   = (remx >= {1'b0, len_p});

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[g] <= ge ? 33'(remx - {1'b0, len_p}) : remx[32:0];
        num_q[g] <= {num_p[15:0], 1'b0};
        quo_q[g] <= {quo_p[15:0], ge};
        len_q[g] <= len_p;
      end
    end
  end

  assign q_o = quo_q[DIV_STAGES-1];

endmodule
